### design/prps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prps_pkg
// Shared types and constants of the perspective rectangle point test.
// ----------------------------------------------------------------------------
package prps_pkg;

	localparam int VEC_BITS  = 16;
	localparam int DOT_BITS  = 41;
	localparam int CFG_BITS  = 64;
	localparam int IDX_BITS  = 3;

	localparam logic [IDX_BITS-1:0] REG_ORIGIN  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_FORWARD = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_RIGHT   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_UP      = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_INV_V   = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_INV_H   = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_RECT    = 3'd6;

	typedef logic signed [DOT_BITS-1:0] dot_t;

endpackage
`default_nettype wire

### design/prps_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prps_axis
// Pipelined interval test of one screen axis: dot * inv against corner * depth.
// ----------------------------------------------------------------------------
module prps_axis
	import prps_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic signed [DOT_BITS-1:0] dot,
	input  wire logic signed [DOT_BITS-1:0] depth,
	input  wire logic [31:0]                inv,
	input  wire logic signed [VEC_BITS-1:0] ca,
	input  wire logic signed [VEC_BITS-1:0] cb,
	output logic                            in_range
);
	// The compare is exact: sign of dot*inv - c*depth*2^10 for both corners.
	logic signed [DOT_BITS+16:0] ph_s1, pl_s1, lo_d_s1, hi_d_s1;
	logic signed [VEC_BITS-1:0]  lo_c, hi_c;
	logic signed [80:0]          plo_s2, phi_s2;
	logic                        ge_s3, le_s3;

	assign lo_c = (ca < cb) ? ca : cb;
	assign hi_c = (ca < cb) ? cb : ca;

	// Stage one: partial products, each about 41 by 17 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1   <= dot * $signed({1'b0, inv[31:16]});
			pl_s1   <= dot * $signed({1'b0, inv[15:0]});
			lo_d_s1 <= depth * lo_c;
			hi_d_s1 <= depth * hi_c;
		end
	end

	// Stage two: full product minus the corner term, both scaled by 2^10.
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s2 <= (81'(ph_s1) <<< 16) + 81'(pl_s1) - (81'(lo_d_s1) <<< 10);
			phi_s2 <= (81'(ph_s1) <<< 16) + 81'(pl_s1) - (81'(hi_d_s1) <<< 10);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ge_s3 <= !plo_s2[80];
			le_s3 <= phi_s2[80] || (phi_s2 == '0);
		end
	end

	assign in_range = ge_s3 && le_s3;
endmodule
`default_nettype wire

### design/perspective_rect_point_select_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_rect_point_select_core
// Tests whether a point projects into a screen rectangle of a pinhole camera.
// ----------------------------------------------------------------------------
// Usage: points arrive on the in channel (in_valid/in_ready) with pos_x,
// pos_y, pos_z and point_id. Each transaction yields exactly one transaction
// on the out channel (out_valid/out_ready) with point_index and inside_res.
// The camera is loaded through cfg_we/cfg_index/cfg_data while idle.
// Throughput is one point per cycle unless the receiver stalls.
// A stall of the receiver freezes the whole pipeline in place; in_ready is
// high whenever the output register is empty or is taken this cycle.
// Reset clears all valid bits and the camera registers to zero.
// Stages: s1 origin subtract, s2 nine products, s3 dot sums,
// s4..s6 axis compare, then the output register.
// ----------------------------------------------------------------------------
module perspective_rect_point_select_core #(
	parameter int INDEX_BITS = 24,
	parameter int COORD_BITS = 21
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic signed [COORD_BITS-1:0] pos_z,
	input  wire logic [INDEX_BITS-1:0]        point_id,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [23:0]                       point_index,
	output logic                              inside_res,
	input  wire logic                         cfg_we,
	input  wire logic [prps_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [prps_pkg::CFG_BITS-1:0] cfg_data
);
	import prps_pkg::*;

	localparam int REL_BITS = COORD_BITS + 1;
	localparam int PRD_BITS = REL_BITS + VEC_BITS;
	localparam int NSTG     = 6;

	logic [62:0] origin_q;
	logic [47:0] fwd_q, rgt_q, up_q;
	logic [31:0] inv_v_q, inv_h_q;
	logic [63:0] rect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0; fwd_q <= '0; rgt_q <= '0; up_q <= '0;
			inv_v_q  <= '0; inv_h_q <= '0; rect_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN:  origin_q <= cfg_data[62:0];
				REG_FORWARD: fwd_q    <= cfg_data[47:0];
				REG_RIGHT:   rgt_q    <= cfg_data[47:0];
				REG_UP:      up_q     <= cfg_data[47:0];
				REG_INV_V:   inv_v_q  <= cfg_data[31:0];
				REG_INV_H:   inv_h_q  <= cfg_data[31:0];
				REG_RECT:    rect_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: every stage advances unless the output is held.
	logic             adv;
	logic [NSTG-1:0]  vld_q;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NSTG-2:0], in_valid};
			out_valid <= vld_q[NSTG-1];
		end
	end

	// Index travels alongside the data.
	logic [INDEX_BITS-1:0] idx_s [NSTG];
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s[0] <= point_id;
			for (int i = 1; i < NSTG; i++) idx_s[i] <= idx_s[i-1];
		end
	end

	// Stage 1: offset from the camera origin.
	logic signed [REL_BITS-1:0] rel_s1 [3];
	logic signed [COORD_BITS-1:0] pos [3];
	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				rel_s1[k] <= REL_BITS'(pos[k])
					- REL_BITS'($signed(origin_q[COORD_BITS*k +: COORD_BITS]));
		end
	end

	// Stage 2: nine products, one per vector component.
	logic signed [PRD_BITS-1:0] pf_s2 [3], pr_s2 [3], pu_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pf_s2[k] <= rel_s1[k] * $signed(fwd_q[VEC_BITS*k +: VEC_BITS]);
				pr_s2[k] <= rel_s1[k] * $signed(rgt_q[VEC_BITS*k +: VEC_BITS]);
				pu_s2[k] <= rel_s1[k] * $signed(up_q[VEC_BITS*k +: VEC_BITS]);
			end
		end
	end

	// Stage 3: dot products.
	dot_t dep_s3, dr_s3, du_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			dep_s3 <= DOT_BITS'(pf_s2[0]) + DOT_BITS'(pf_s2[1]) + DOT_BITS'(pf_s2[2]);
			dr_s3  <= DOT_BITS'(pr_s2[0]) + DOT_BITS'(pr_s2[1]) + DOT_BITS'(pr_s2[2]);
			du_s3  <= DOT_BITS'(pu_s2[0]) + DOT_BITS'(pu_s2[1]) + DOT_BITS'(pu_s2[2]);
		end
	end

	// Depth sign follows the axis units through their three stages.
	logic [2:0] front_q;
	always_ff @(posedge clk) begin
		if (adv) front_q <= {front_q[1:0], (dep_s3 > 0)};
	end

	logic hin, vin;
	prps_axis u_axis_h (
		.clk(clk), .en(adv), .dot(dr_s3), .depth(dep_s3), .inv(inv_h_q),
		.ca($signed(rect_q[15:0])), .cb($signed(rect_q[47:32])), .in_range(hin)
	);
	prps_axis u_axis_v (
		.clk(clk), .en(adv), .dot(du_s3), .depth(dep_s3), .inv(inv_v_q),
		.ca($signed(rect_q[31:16])), .cb($signed(rect_q[63:48])), .in_range(vin)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			point_index <= 24'(idx_s[NSTG-1]);
			inside_res  <= front_q[2] && hin && vin;
		end
	end
endmodule
`default_nettype wire
